/* hw/rtl/hi_pkg.sv */
// hi_pkg: shared types, widths, microcode format and program for the harmonic integrator.
// Holds the CORDIC arctangent table. No dependencies.
package hi_pkg;

    // Field and register widths
    localparam int ERR_W      = 24;
    localparam int STEP_W     = 20;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 31;
    localparam int INT_W      = 32;
    localparam int TRIG_W     = 16;
    localparam int TRIG_FRAC  = 15;
    localparam int CORR_W     = 33;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    // CORDIC: Q2.30 words, 32-bit full-turn angle
    localparam int ANGLE_W      = 32;
    localparam int CW_W         = 33;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = 4;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);
    localparam logic signed [CW_W-1:0] CORDIC_K = 33'sd652032874;

    localparam logic [ANGLE_W-1:0] TURN_ATAN [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTEGRAL_GAIN  = 1'd0,
        REG_INTEGRAL_LIMIT = 1'd1
    } t_reg_idx;

    typedef struct packed {
        logic              load;
        logic              iterate;
        logic [ITER_W-1:0] iter;
    } t_cordic_ctl;

    // Microcode word
    typedef enum logic [2:0] {
        UOP_NOP, UOP_LOAD, UOP_CORDIC, UOP_TRIG, UOP_INT_S, UOP_INT_C, UOP_SAVE, UOP_OUT
    } t_uop;

    typedef enum logic [2:0] {
        OPA_SIN, OPA_COS, OPA_PQ15, OPA_PFRAC, OPA_SINT, OPA_CINT
    } t_opa;

    typedef enum logic [2:0] {
        OPB_GAIN, OPB_ERR, OPB_STEP, OPB_SIN, OPB_COS
    } t_opb;

    // Hold conditions: while true the step counter stays put, otherwise it loads the target
    typedef enum logic [1:0] {
        COND_NONE, COND_NO_INPUT, COND_CORDIC_MORE, COND_OUT_BUSY
    } t_cond;

    localparam int STEP_CNT_W = 4;
    typedef logic [STEP_CNT_W-1:0] t_step;

    typedef struct packed {
        t_uop  op;
        logic  mul_en;
        t_opa  a_sel;
        t_opb  b_sel;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step ST_IDLE   = 4'd0;
    localparam t_step ST_CORDIC = 4'd1;
    localparam t_step ST_TRIG   = 4'd2;
    localparam t_step ST_S_GAIN = 4'd3;
    localparam t_step ST_S_ERR  = 4'd4;
    localparam t_step ST_S_STEP = 4'd5;
    localparam t_step ST_S_INT  = 4'd6;
    localparam t_step ST_C_ERR  = 4'd7;
    localparam t_step ST_C_STEP = 4'd8;
    localparam t_step ST_C_INT  = 4'd9;
    localparam t_step ST_PROD_C = 4'd10;
    localparam t_step ST_OUT    = 4'd11;

    function automatic t_uword uw(input t_uop op, input logic mul, input t_opa a,
                                  input t_opb b, input t_cond c, input t_step tgt);
        return '{op, mul, a, b, c, tgt};
    endfunction

    // Program ROM
    function automatic t_uword hi_ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_IDLE:   w = uw(UOP_LOAD,   1'b0, OPA_SIN,   OPB_GAIN, COND_NO_INPUT,    ST_CORDIC);
            ST_CORDIC: w = uw(UOP_CORDIC, 1'b0, OPA_SIN,   OPB_GAIN, COND_CORDIC_MORE, ST_TRIG);
            ST_TRIG:   w = uw(UOP_TRIG,   1'b0, OPA_SIN,   OPB_GAIN, COND_NONE,        ST_S_GAIN);
            ST_S_GAIN: w = uw(UOP_NOP,    1'b1, OPA_SIN,   OPB_GAIN, COND_NONE,        ST_S_ERR);
            ST_S_ERR:  w = uw(UOP_NOP,    1'b1, OPA_PQ15,  OPB_ERR,  COND_NONE,        ST_S_STEP);
            ST_S_STEP: w = uw(UOP_NOP,    1'b1, OPA_PFRAC, OPB_STEP, COND_NONE,        ST_S_INT);
            ST_S_INT:  w = uw(UOP_INT_S,  1'b1, OPA_COS,   OPB_GAIN, COND_NONE,        ST_C_ERR);
            ST_C_ERR:  w = uw(UOP_NOP,    1'b1, OPA_PQ15,  OPB_ERR,  COND_NONE,        ST_C_STEP);
            ST_C_STEP: w = uw(UOP_NOP,    1'b1, OPA_PFRAC, OPB_STEP, COND_NONE,        ST_C_INT);
            ST_C_INT:  w = uw(UOP_INT_C,  1'b1, OPA_SINT,  OPB_SIN,  COND_NONE,        ST_PROD_C);
            ST_PROD_C: w = uw(UOP_SAVE,   1'b1, OPA_CINT,  OPB_COS,  COND_NONE,        ST_OUT);
            ST_OUT:    w = uw(UOP_OUT,    1'b0, OPA_SIN,   OPB_GAIN, COND_OUT_BUSY,    ST_IDLE);
            default:   w = uw(UOP_NOP,    1'b0, OPA_SIN,   OPB_GAIN, COND_NONE,        ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/harmonic_integrator.sv */
// harmonic_integrator: microcoded sine/cosine harmonic integrator, top level.
// Depends on hi_pkg and hi_cordic.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one transaction: error sample,
//   phase and phase step. Output channel (o_out_valid / i_out_ready) returns one
//   correction per input transaction, in order.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   write only while the block is idle. Index 0 is the gain, 1 the limit.
// Timing
//   A short program in a ROM steps a CORDIC unit and a single shared 24-bit by
//   33-bit multiplier (at the default FRAC_BITS). The 16 CORDIC iterations (one
//   per cycle), one step to latch sine and cosine, eight multiply/integrate steps
//   and the output step run in that order from acceptance to o_out_valid; a new
//   transaction is taken only once the program is back on its idle step.
//   The block holds one transaction at a time; o_in_ready is high only on the
//   idle step of the program.
// Reset (synchronous, active low)
//   Both integrators clear, gain goes to zero, limit to full scale, output empty.
// Back-pressure
//   The result sits in an output register, so the next transaction can be taken
//   while it waits. If a new result is ready and the old one is still not taken,
//   the program holds on its last step until the output register frees up.
module harmonic_integrator #(
    parameter int PHASE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hi_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [hi_pkg::ERR_W-1:0]      i_error_sample,
    input  logic [PHASE_BITS-1:0]                i_phase,
    input  logic signed [hi_pkg::STEP_W-1:0]     i_phase_step,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [hi_pkg::CORR_W-1:0]     o_correction
);
    import hi_pkg::*;

    // a = gain*trig >> 15, b = a*err >> F, inc = b*step >> F
    localparam int A_W   = GAIN_W + TRIG_W - TRIG_FRAC;
    localparam int B_W   = A_W + ERR_W - FRAC_BITS;
    localparam int INC_W = B_W + STEP_W - FRAC_BITS;
    localparam int MA_W  = (B_W > INT_W) ? B_W : INT_W;   // wide multiplier operand
    localparam int MB_W  = GAIN_W;                        // narrow multiplier operand
    localparam int P_W   = MA_W + MB_W;
    localparam int SUM_W = ((INC_W > INT_W) ? INC_W : INT_W) + 1;
    localparam int SP_W  = TRIG_W + INT_W;                // trig * integrator
    localparam int CSH_W = SP_W + 1 - TRIG_FRAC;

    localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
    localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

    // Sequencer
    t_step              r_step, n_step;
    logic [ITER_W-1:0]  r_iter, n_iter;
    t_uword             uword;
    logic               hold;
    logic               accept;

    // Configuration
    logic signed [GAIN_W-1:0] r_gain, n_gain;
    logic [LIMIT_W-1:0]       r_limit, n_limit;

    // Datapath
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [STEP_W-1:0] r_pstep, n_pstep;
    t_trig                    r_sin, n_sin, r_cos, n_cos;
    logic signed [P_W-1:0]    r_prod, n_prod;
    logic signed [SP_W-1:0]   r_acc, n_acc;
    logic signed [INT_W-1:0]  r_si, n_si, r_ci, n_ci;
    logic                     r_out_valid, n_out_valid;
    logic signed [CORR_W-1:0] r_correction, n_correction;

    logic signed [MA_W-1:0]   op_a;
    logic signed [MB_W-1:0]   op_b;
    logic signed [P_W-1:0]    mul_res;

    logic signed [INC_W-1:0]  inc;
    logic signed [INT_W-1:0]  int_src, int_new, lim32;
    logic signed [SUM_W-1:0]  int_sum, lim_pos;

    logic signed [SP_W:0]     corr_sum;
    logic signed [CSH_W-1:0]  corr_sh;
    logic signed [CORR_W-1:0] corr_sat;

    t_cordic_ctl              cordic_ctl;
    t_trig                    cordic_sin, cordic_cos;

    hi_cordic #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_ctl   (cordic_ctl),
        .i_phase (i_phase),
        .o_sin   (cordic_sin),
        .o_cos   (cordic_cos)
    );

    // Shared multiplier operand selection
    always_comb begin
        unique case (uword.a_sel)
            OPA_SIN:   op_a = MA_W'(r_sin);
            OPA_COS:   op_a = MA_W'(r_cos);
            OPA_PQ15:  op_a = MA_W'(signed'(r_prod[TRIG_FRAC +: A_W]));
            OPA_PFRAC: op_a = MA_W'(signed'(r_prod[FRAC_BITS +: B_W]));
            OPA_SINT:  op_a = MA_W'(r_si);
            OPA_CINT:  op_a = MA_W'(r_ci);
            default:   op_a = '0;
        endcase
        unique case (uword.b_sel)
            OPB_GAIN: op_b = r_gain;
            OPB_ERR:  op_b = MB_W'(r_err);
            OPB_STEP: op_b = MB_W'(r_pstep);
            OPB_SIN:  op_b = MB_W'(r_sin);
            OPB_COS:  op_b = MB_W'(r_cos);
            default:  op_b = '0;
        endcase
        mul_res = op_a * op_b;
    end

    // Integrator update: one adder and clamp, shared by both integrators
    always_comb begin
        int_src = (uword.op == UOP_INT_C) ? r_ci : r_si;
        inc     = signed'(r_prod[FRAC_BITS +: INC_W]);
        int_sum = SUM_W'(int_src) + SUM_W'(inc);
        lim32   = signed'({1'b0, r_limit});
        lim_pos = SUM_W'(lim32);
        if (int_sum > lim_pos) begin
            int_new = lim32;
        end else if (int_sum < -lim_pos) begin
            int_new = -lim32;
        end else begin
            int_new = int_sum[INT_W-1:0];
        end
    end

    // Correction: sin*si held in r_acc, cos*ci in r_prod
    always_comb begin
        corr_sum = (SP_W+1)'(r_acc) + (SP_W+1)'(signed'(r_prod[SP_W-1:0]));
        corr_sh  = corr_sum[SP_W:TRIG_FRAC];
        if (corr_sh > CSH_W'(CORR_MAX)) begin
            corr_sat = CORR_MAX;
        end else if (corr_sh < CSH_W'(CORR_MIN)) begin
            corr_sat = CORR_MIN;
        end else begin
            corr_sat = corr_sh[CORR_W-1:0];
        end
    end

    // Sequencer and next-state logic
    always_comb begin
        uword = hi_ucode(r_step);

        unique case (uword.cond)
            COND_NONE:        hold = 1'b0;
            COND_NO_INPUT:    hold = !i_in_valid;
            COND_CORDIC_MORE: hold = (r_iter != ITER_LAST);
            COND_OUT_BUSY:    hold = r_out_valid && !i_out_ready;
        endcase

        o_in_ready = (uword.op == UOP_LOAD);
        accept     = i_in_valid && o_in_ready;
        n_step     = hold ? r_step : uword.target;

        n_iter       = r_iter;
        n_gain       = r_gain;
        n_limit      = r_limit;
        n_err        = r_err;
        n_pstep      = r_pstep;
        n_sin        = r_sin;
        n_cos        = r_cos;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_si         = r_si;
        n_ci         = r_ci;
        n_out_valid  = r_out_valid;
        n_correction = r_correction;

        cordic_ctl.load    = 1'b0;
        cordic_ctl.iterate = 1'b0;
        cordic_ctl.iter    = r_iter;

        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_INTEGRAL_GAIN:  n_gain  = i_cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: n_limit = i_cfg_data[LIMIT_W-1:0];
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (uword.mul_en) begin
            n_prod = mul_res;
        end

        unique case (uword.op)
            UOP_NOP: begin
            end
            UOP_LOAD: begin
                if (accept) begin
                    n_err           = i_error_sample;
                    n_pstep         = i_phase_step;
                    n_iter          = '0;
                    cordic_ctl.load = 1'b1;
                end
            end
            UOP_CORDIC: begin
                cordic_ctl.iterate = 1'b1;
                n_iter             = r_iter + 1'b1;
            end
            UOP_TRIG: begin
                n_sin = cordic_sin;
                n_cos = cordic_cos;
            end
            UOP_INT_S: begin
                n_si = int_new;
            end
            UOP_INT_C: begin
                n_ci = int_new;
            end
            UOP_SAVE: begin
                n_acc = r_prod[SP_W-1:0];
            end
            UOP_OUT: begin
                if (!hold) begin
                    n_out_valid  = 1'b1;
                    n_correction = corr_sat;
                end
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_gain      <= '0;
            r_limit     <= LIMIT_RESET;
            r_si        <= '0;
            r_ci        <= '0;
        end else begin
            r_step      <= n_step;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
            r_gain      <= n_gain;
            r_limit     <= n_limit;
            r_si        <= n_si;
            r_ci        <= n_ci;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_err        <= n_err;
        r_pstep      <= n_pstep;
        r_sin        <= n_sin;
        r_cos        <= n_cos;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_correction <= n_correction;
    end

    assign o_out_valid  = r_out_valid;
    assign o_correction = r_correction;

endmodule

/* hw/rtl/hi_cordic.sv */
// hi_cordic: one-iteration-per-cycle CORDIC giving Q1.15 sine and cosine of a full-turn phase.
// Depends on hi_pkg; stepped by the sequencer in harmonic_integrator.
module hi_cordic #(
    parameter int PHASE_BITS = 16
) (
    input  logic                 i_clk,
    input  hi_pkg::t_cordic_ctl  i_ctl,
    input  logic [PHASE_BITS-1:0] i_phase,
    output hi_pkg::t_trig        o_sin,
    output hi_pkg::t_trig        o_cos
);
    import hi_pkg::*;

    localparam int PAD_W = ANGLE_W - PHASE_BITS;

    logic signed [CW_W-1:0] r_x, r_y, r_z;
    logic signed [CW_W-1:0] n_x, n_y, n_z;
    logic                   r_flip, n_flip;

    logic [ANGLE_W-1:0]     angle;
    logic signed [CW_W-1:0] x_sh, y_sh, atan, x_out, y_out;

    // Round to nearest, then saturate to Q1.15
    function automatic t_trig to_q15(input logic signed [CW_W-1:0] v);
        logic signed [CW_W:0]           r;
        logic signed [CW_W-TRIG_FRAC:0] sh;
        r  = (CW_W+1)'(v) + (CW_W+1)'(16384);
        sh = r[CW_W:TRIG_FRAC];
        if (sh > (CW_W-TRIG_FRAC+1)'(32767)) begin
            return 16'sh7FFF;
        end else if (sh < -(CW_W-TRIG_FRAC+1)'(32768)) begin
            return 16'sh8000;
        end else begin
            return sh[TRIG_W-1:0];
        end
    endfunction

    always_comb begin
        angle = {i_phase, {PAD_W{1'b0}}};
        x_sh  = r_x >>> i_ctl.iter;
        y_sh  = r_y >>> i_ctl.iter;
        atan  = CW_W'(TURN_ATAN[i_ctl.iter]);

        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_flip = r_flip;

        if (i_ctl.load) begin
            // second and third quadrants: rotate by half a turn, negate at the end
            n_flip = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
            n_x    = CORDIC_K;
            n_y    = '0;
            n_z    = CW_W'(signed'({angle[ANGLE_W-1] ^ n_flip, angle[ANGLE_W-2:0]}));
        end else if (i_ctl.iterate) begin
            if (!r_z[CW_W-1]) begin
                n_x = r_x - y_sh;
                n_y = r_y + x_sh;
                n_z = r_z - atan;
            end else begin
                n_x = r_x + y_sh;
                n_y = r_y - x_sh;
                n_z = r_z + atan;
            end
        end

        y_out = r_flip ? -r_y : r_y;
        x_out = r_flip ? -r_x : r_x;
        o_sin = to_q15(y_out);
        o_cos = to_q15(x_out);
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= n_flip;
    end

endmodule

/* hw/rtl/hi_checker.sv */
// hi_checker: port-level assertions for harmonic_integrator, bound to the top level.
// Depends on hi_pkg.
module hi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [hi_pkg::CORR_W-1:0]  o_correction
);
    import hi_pkg::*;

    // Reset empties the output register and leaves the block ready
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

    // One transaction at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready straight after accept");

    // A result cannot appear the cycle after its input was taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result too early");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_correction)))
        else $error("stalled result dropped or changed");

endmodule

bind harmonic_integrator hi_checker u_hi_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for harmonic_integrator, directed cases then random traffic.
// Depends on hi_pkg; corrections are predicted by an in-bench fixed-point integrator model.
module tb;
    import hi_pkg::*;

    localparam int PH_BITS          = 16;
    localparam int F_BITS           = 16;
    // Longest legitimate quiet spell is the output hold-off
    localparam int STALL_LIMIT      = 4000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int DRAIN_CYCLES     = 40;

    localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
    localparam logic signed [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0]        GAIN_ONE = 24'h010000;
    localparam logic [GAIN_W-1:0]        GAIN_MAX = 24'h7FFFFF;
    localparam logic [GAIN_W-1:0]        GAIN_MIN = 24'h800000;
    localparam logic [LIMIT_W-1:0]       LIM_MAX  = {LIMIT_W{1'b1}};

    // All block inputs start at known values
    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_ready;
    logic signed [ERR_W-1:0]    i_error_sample = '0;
    logic [PH_BITS-1:0]         i_phase        = '0;
    logic signed [STEP_W-1:0]   i_phase_step   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready    = 1'b0;
    logic signed [CORR_W-1:0]   o_correction;

    harmonic_integrator #(
        .PHASE_BITS (PH_BITS),
        .FRAC_BITS  (F_BITS)
    ) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: register copies and the two integrators
    // ------------------------------------------------------------------
    longint gain_q  = 0;
    longint limit_q = longint'(LIMIT_RESET);
    longint sin_acc = 0;
    longint cos_acc = 0;

    typedef struct {
        int                       id;
        logic signed [CORR_W-1:0] corr;
    } t_corr_exp;

    t_corr_exp pending_corr[$];

    int  sent_count     = 0;
    int  checked_count  = 0;
    int  mismatch_count = 0;
    int  clamp_count    = 0;
    int  reg_writes     = 0;
    bit  gapless        = 1'b0;  // both sides stop idling while set
    int  hold_seq       = 0;     // bump to ask the receiver for one long hold-off

    // Q2.30 -> Q1.15, round half up, saturate (a trig value of exactly one lands on 32767)
    function automatic longint q15_round(input longint v30);
        longint r;
        r = (v30 + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // 16-step rotation CORDIC on a 32-bit full-turn angle. Quadrants 1 and 2 are
    // rotated by half a turn first and the result negated afterwards.
    function automatic void phase_to_trig(input logic [PH_BITS-1:0] ph,
                                          output longint s, output longint c);
        logic [31:0] ang;
        longint      x, y, z, t;
        bit          flip;
        ang  = 32'(ph) << (32 - PH_BITS);
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        if (flip)
            ang = ang + 32'h8000_0000;
        z = longint'($signed(ang));
        x = longint'(CORDIC_K);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(TURN_ATAN[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(TURN_ATAN[i]);
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = q15_round(y);
        c = q15_round(x);
    endfunction

    // gain*trig*err*step with truncation (toward minus infinity) after every product
    function automatic longint integrator_increment(input longint trig, input longint err,
                                                    input longint stp);
        longint a, b;
        a = (gain_q * trig) >>> 15;
        b = (a * err) >>> F_BITS;
        return (b * stp) >>> F_BITS;
    endfunction

    // Advances both integrators by one transaction and returns the expected correction
    function automatic logic signed [CORR_W-1:0] predict_correction(
        input logic signed [ERR_W-1:0] err, input logic [PH_BITS-1:0] ph,
        input logic signed [STEP_W-1:0] stp);
        longint s, c, e, d, sum;
        e = longint'(err);
        d = longint'(stp);
        phase_to_trig(ph, s, c);
        sin_acc = sin_acc + integrator_increment(s, e, d);
        cos_acc = cos_acc + integrator_increment(c, e, d);
        if (sin_acc > limit_q || sin_acc < -limit_q || cos_acc > limit_q || cos_acc < -limit_q)
            clamp_count++;
        sin_acc = clamp_to(sin_acc, -limit_q, limit_q);
        cos_acc = clamp_to(cos_acc, -limit_q, limit_q);
        sum = (s * sin_acc + c * cos_acc) >>> 15;
        sum = clamp_to(sum, -(longint'(1) <<< 32), (longint'(1) <<< 32) - 1);
        return sum[CORR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One transaction: optional random gap, then valid held until the handshake.
    // Valid is left high after acceptance; the next call or settle() decides its fate.
    task automatic send_txn(input logic signed [ERR_W-1:0] err, input logic [PH_BITS-1:0] ph,
                            input logic signed [STEP_W-1:0] stp);
        t_corr_exp next_exp;
        @(negedge i_clk);
        while (!gapless && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_error_sample <= err;
        i_phase        <= ph;
        i_phase_step   <= stp;
        do @(posedge i_clk); while (!o_in_ready);
        next_exp.id   = sent_count;
        next_exp.corr = predict_correction(err, ph, stp);
        pending_corr.push_back(next_exp);
        sent_count++;
    endtask

    // Drop valid and wait for every outstanding correction; each transaction gives
    // exactly one, so an empty queue means the block is idle.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_corr.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_INTEGRAL_GAIN:  gain_q  = longint'($signed(data[GAIN_W-1:0]));
            REG_INTEGRAL_LIMIT: limit_q = longint'(data[LIMIT_W-1:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    // Upper data bits are junk on a gain write; only the low 24 should count
    task automatic set_gain(input logic [GAIN_W-1:0] g);
        write_reg(REG_INTEGRAL_GAIN, {(CFG_DATA_W-GAIN_W)'($urandom), g});
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] lim);
        write_reg(REG_INTEGRAL_LIMIT, lim);
    endtask

    // Random transactions with a bias toward field extremes and quadrant edges
    task automatic send_random(input int n);
        logic signed [ERR_W-1:0]  err;
        logic [PH_BITS-1:0]       ph;
        logic signed [STEP_W-1:0] stp;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       err = ERR_MAX;
                1:       err = ERR_MIN;
                2:       err = '0;
                default: err = ERR_W'($urandom);
            endcase
            case ($urandom_range(7))
                0:       ph = PH_BITS'($urandom_range(3)) << (PH_BITS - 2);
                1:       ph = (PH_BITS'($urandom_range(3)) << (PH_BITS - 2))
                              + PH_BITS'($urandom_range(2)) - PH_BITS'(1);
                default: ph = PH_BITS'($urandom);
            endcase
            case ($urandom_range(9))
                0:       stp = STEP_MAX;
                1:       stp = STEP_MIN;
                2:       stp = '0;
                default: stp = STEP_W'($urandom);
            endcase
            send_txn(err, ph, stp);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one counted hold-off on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    int hold_seen = 0;

    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= 300 + $urandom_range(100);
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= gapless || ($urandom_range(99) >= 29);
        end
    end

    // Compare every accepted correction with the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_corr_exp oldest;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_corr.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MISMATCHES)
                    $display("unexpected correction %0d with nothing outstanding", o_correction);
            end else begin
                oldest = pending_corr.pop_front();
                checked_count++;
                if (o_correction !== oldest.corr) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                        $display("correction mismatch, transaction %0d: expected %0d, got %0d",
                                 oldest.id, oldest.corr, o_correction);
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Gain resets to zero, so nothing integrates and corrections stay at zero
    task automatic check_reset_state();
        send_txn(ERR_MAX, 16'h2000, STEP_MAX);
        send_txn(ERR_MIN, 16'hA000, STEP_MIN);
    endtask

    // Quadrant boundaries and diagonals; phase zero gives a full-scale cosine
    task automatic check_quadrant_trig();
        logic [PH_BITS-1:0] quad [8];
        quad = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                 16'h2000, 16'h6000, 16'hFFFF, 16'h0001};
        set_gain(GAIN_ONE);
        set_limit(LIM_MAX);
        foreach (quad[i])
            send_txn(24'sh010000, quad[i], 20'sh10000);
    endtask

    task automatic check_field_extremes();
        set_gain(GAIN_MAX);
        send_txn(ERR_MAX, 16'h0000, STEP_MAX);
        send_txn(ERR_MIN, 16'h0000, STEP_MAX);
        send_txn(ERR_MAX, 16'h4000, STEP_MIN);
        send_txn(ERR_MIN, 16'hFFFF, STEP_MIN);
        send_txn('0,      16'h8000, STEP_MAX);
        send_txn(ERR_MAX, 16'hC000, '0);
    endtask

    // Zero limit pins both integrators, whatever the drive
    task automatic check_zero_limit();
        set_limit('0);
        send_txn(ERR_MAX, 16'h1000, STEP_MAX);
        send_txn(ERR_MIN, 16'h5000, STEP_MAX);
        send_txn(ERR_MAX, 16'hE000, STEP_MIN);
    endtask

    // Most negative gain against a small limit: both integrators are driven onto the negative rail
    task automatic check_integrator_clamp();
        set_limit(31'h0001_0000);
        set_gain(GAIN_MIN);
        send_txn(ERR_MAX, 16'h2000, STEP_MAX);
        send_txn(ERR_MAX, 16'h2000, STEP_MAX);
        send_txn(ERR_MIN, 16'h9000, STEP_MAX);
        send_txn(ERR_MIN, 16'h9000, STEP_MAX);
    endtask

    // Several register settings, extremes first, then random ones
    task automatic run_random_settings();
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: begin set_gain(GAIN_MAX); set_limit(LIM_MAX); end
                1: begin set_gain(GAIN_MIN); set_limit(LIMIT_W'($urandom_range(1 << 20))); end
                2: begin set_gain(GAIN_W'($urandom)); set_limit('0); end
                3: begin
                    set_gain(GAIN_W'($urandom_range(1 << 17)));
                    set_limit(LIMIT_W'($urandom));
                end
                default: begin set_gain(GAIN_W'($urandom)); set_limit(LIMIT_W'($urandom)); end
            endcase
            send_random(250);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic run_without_gaps();
        set_gain(-GAIN_W'($urandom_range(1 << 18)));
        set_limit(LIMIT_W'($urandom_range(1 << 28)));
        gapless = 1'b1;
        send_random(150);
        gapless = 1'b0;
    endtask

    // Receiver asks for one long hold-off; the block fills and stalls its input
    task automatic run_output_holdoff();
        set_gain(GAIN_W'($urandom));
        set_limit(LIM_MAX);
        hold_seq++;
        send_random(125);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_reset_state();
        check_quadrant_trig();
        check_field_extremes();
        check_zero_limit();
        check_integrator_clamp();
        run_random_settings();
        run_without_gaps();
        run_output_holdoff();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_corr.size() != 0) begin
            $display("%0d corrections never arrived", pending_corr.size());
            mismatch_count += pending_corr.size();
        end

        $display("%0d transactions over %0d register writes; %0d corrections compared, %0d failed.",
                 sent_count, reg_writes, checked_count, mismatch_count);
        $display("Integrator clamping seen on %0d steps; output hold-off and gapless run included.",
                 clamp_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
